// ===== hdl/c3br_pkg.sv =====
package c3br_pkg;

  localparam int MaxHeight = 32;
  localparam int MaxWidth  = 32;
  localparam int MaxInCh   = 64;
  localparam int MaxOutCh  = 64;
  localparam int LineCols  = MaxWidth + 2;
  localparam int WeightDepth = 9 * MaxInCh * MaxOutCh;
  localparam int LineDepth   = 3 * LineCols * MaxInCh;
  localparam int WAddrW = $clog2(WeightDepth);
  localparam int LAddrW = $clog2(LineDepth);
  localparam int BAddrW = $clog2(MaxOutCh);
  localparam int AccW   = 42;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_PIXEL  = 2'd2,
    OP_FLUSH  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_HEIGHT = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_IN_CH  = 2'd2,
    REG_OUT_CH = 2'd3
  } reg_idx_t;

endpackage

// ===== hdl/conv3x3_bias_relu.sv =====
// 3x3 convolution, zero padding of one, bias and ReLU over a frame streamed in raster
// order, channel-minor (tuser = op: load weight, load bias, pixel, border flush). The
// host sends one flush per right-column and bottom-row border position. Each completed
// position at padded row >= 2 and column >= 2 emits out_channels results for the pixel
// above-left of it, tlast on the final channel. Loads and non-emitting items leave the
// block idle. An emitting item runs 9 * in_channels multiply-accumulates per output
// channel, one per cycle, bounded by the single read port of the weight memory.
// Results sit in an output register, so a stalled consumer holds at most one result.
// Register writes (index 0 height, 1 width, 2 in_channels, 3 out_channels) are clamped
// to [1, max] and restart the frame; write them only while the block is idle.
module conv3x3_bias_relu
  import c3br_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] index, [31:16] value
  input  logic [1:0]  in_tuser,   // [1:0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [4:0] out_row, [9:5] out_col, [15:10] out_channel,
                                  // [30:16] out_value, [31] zero
  output logic        out_tlast,  // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {S_IDLE, S_BIAS, S_MAC, S_DRAIN, S_EMIT} state_t;

  state_t      state_r;
  logic [5:0]  height_r, width_r;
  logic [6:0]  in_ch_r, out_ch_r;
  logic [5:0]  pos_row_r, pos_col_r, pos_ch_r;
  logic [1:0]  pos_slot_r;           // pos_row mod 3

  // emission context
  logic [4:0]  er_r, ec_r;
  logic [1:0]  eslot_r, slot_r;
  logic [5:0]  f_r, ch_r;
  logic [1:0]  kr_r, kc_r;
  logic [3:0]  k_r;
  logic        init_r, v1_r, v2_r, pad0_r;
  logic signed [31:0]     prod_r;
  logic signed [AccW-1:0] acc_r;

  logic        out_valid_r, out_last_r;
  logic [4:0]  out_row_r, out_col_r;
  logic [5:0]  out_ch_r2;
  logic [14:0] out_val_r;

  // input fields
  logic [15:0] idx, val;
  op_t         op;
  assign idx = in_tdata[15:0];
  assign val = in_tdata[31:16];
  assign op  = op_t'(in_tuser);

  logic in_fire;
  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  logic interior;
  assign interior = (pos_row_r <= height_r) && (pos_col_r <= width_r);

  // memories
  logic              w_we, b_we, l_we;
  logic [WAddrW-1:0] w_raddr;
  logic [LAddrW-1:0] l_waddr, l_raddr;
  logic [15:0]       w_rdata, b_rdata, l_rdata;

  assign w_we = in_fire && (op == OP_WEIGHT) && (idx < 16'(WeightDepth));
  assign b_we = in_fire && (op == OP_BIAS) && (idx < 16'(MaxOutCh));
  assign l_we = in_fire && (op == OP_PIXEL) && interior;

  assign l_waddr = LAddrW'((32'(pos_slot_r) * LineCols + 32'(pos_col_r)) * MaxInCh
                   + 32'(pos_ch_r));

  // padded coordinates of the current tap
  logic [5:0] prow, pcol;
  logic       pad;
  assign prow = 6'(er_r) + 6'(kr_r);
  assign pcol = 6'(ec_r) + 6'(kc_r);
  assign pad  = (prow == 6'd0) || (prow > height_r) || (pcol == 6'd0) || (pcol > width_r);

  assign w_raddr = WAddrW'((32'(k_r) * MaxInCh + 32'(ch_r)) * MaxOutCh + 32'(f_r));
  assign l_raddr = LAddrW'((32'(slot_r) * LineCols + 32'(pcol)) * MaxInCh + 32'(ch_r));

  c3br_ram #(.Width(16), .Depth(WeightDepth)) u_weight (
    .clk, .we(w_we), .waddr(idx[WAddrW-1:0]), .wdata(val),
    .raddr(w_raddr), .rdata(w_rdata));

  c3br_ram #(.Width(16), .Depth(MaxOutCh)) u_bias (
    .clk, .we(b_we), .waddr(idx[BAddrW-1:0]), .wdata(val),
    .raddr(f_r), .rdata(b_rdata));

  c3br_ram #(.Width(16), .Depth(LineDepth)) u_line (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(val),
    .raddr(l_raddr), .rdata(l_rdata));

  // position completion
  logic complete, emit;
  assign complete = in_fire && (((op == OP_PIXEL) && interior && (7'(pos_ch_r) + 7'd1 == in_ch_r))
                    || ((op == OP_FLUSH) && !interior));
  assign emit = complete && (pos_row_r >= 6'd2) && (pos_col_r >= 6'd2);

  logic last_tap;
  assign last_tap = (kr_r == 2'd2) && (kc_r == 2'd2) && (7'(ch_r) + 7'd1 == in_ch_r);

  // result rounding
  logic [AccW-1:0] rnd;
  logic [14:0]     relu;
  assign rnd = AccW'(acc_r) + AccW'(128);
  always_comb begin
    if (acc_r <= 0) begin
      relu = 15'd0;
    end else if (rnd[AccW-1:8] > (AccW-8)'(32767)) begin
      relu = 15'h7fff;
    end else begin
      relu = rnd[22:8];
    end
  end

  function automatic logic [5:0] clamp6(input logic [15:0] v, input int mx);
    if (v == 16'd0) return 6'd1;
    if (v > 16'(mx)) return 6'(mx);
    return v[5:0];
  endfunction

  function automatic logic [6:0] clamp7(input logic [15:0] v, input int mx);
    if (v == 16'd0) return 7'd1;
    if (v > 16'(mx)) return 7'(mx);
    return v[6:0];
  endfunction

  always_ff @(posedge clk) begin
    // MAC pipeline: read data, then product, then accumulate
    v1_r   <= (state_r == S_MAC);
    v2_r   <= v1_r;
    prod_r <= pad0_r ? 32'sd0 : $signed(w_rdata) * $signed(l_rdata);
    if (init_r) begin
      acc_r <= AccW'($signed(b_rdata)) <<< 8;
    end else if (v2_r) begin
      acc_r <= acc_r + AccW'(prod_r);
    end
    pad0_r <= pad;
    init_r <= (state_r == S_BIAS);

    if (!rst_n) begin
      state_r     <= S_IDLE;
      height_r    <= 6'(24);
      width_r     <= 6'(24);
      in_ch_r     <= 7'(3);
      out_ch_r    <= 7'(64);
      pos_row_r   <= 6'd1;
      pos_col_r   <= 6'd1;
      pos_ch_r    <= 6'd0;
      pos_slot_r  <= 2'd1;
      out_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      init_r      <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_valid) begin
        case (reg_idx_t'(cfg_index))
          REG_HEIGHT: height_r <= clamp6(cfg_data, MaxHeight);
          REG_WIDTH:  width_r  <= clamp6(cfg_data, MaxWidth);
          REG_IN_CH:  in_ch_r  <= clamp7(cfg_data, MaxInCh);
          REG_OUT_CH: out_ch_r <= clamp7(cfg_data, MaxOutCh);
          default:    ;
        endcase
        pos_row_r  <= 6'd1;
        pos_col_r  <= 6'd1;
        pos_ch_r   <= 6'd0;
        pos_slot_r <= 2'd1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire && (op == OP_PIXEL) && interior) begin
            pos_ch_r <= complete ? 6'd0 : pos_ch_r + 6'd1;
          end
          if (complete) begin
            if (pos_col_r + 6'd1 > width_r + 6'd1) begin
              pos_col_r <= 6'd1;
              if (pos_row_r + 6'd1 > height_r + 6'd1) begin
                pos_row_r  <= 6'd1;
                pos_slot_r <= 2'd1;
              end else begin
                pos_row_r  <= pos_row_r + 6'd1;
                pos_slot_r <= (pos_slot_r == 2'd2) ? 2'd0 : pos_slot_r + 2'd1;
              end
            end else begin
              pos_col_r <= pos_col_r + 6'd1;
            end
          end
          if (emit) begin
            er_r    <= 5'(pos_row_r - 6'd2);
            ec_r    <= 5'(pos_col_r - 6'd2);
            // row-2 is congruent to row+1 mod 3
            eslot_r <= (pos_slot_r == 2'd2) ? 2'd0 : pos_slot_r + 2'd1;
            f_r     <= 6'd0;
            state_r <= S_BIAS;
          end
        end
        S_BIAS: begin
          ch_r    <= 6'd0;
          kr_r    <= 2'd0;
          kc_r    <= 2'd0;
          k_r     <= 4'd0;
          slot_r  <= eslot_r;
          state_r <= S_MAC;
        end
        S_MAC: begin
          k_r <= k_r + 4'd1;
          if (kc_r == 2'd2) begin
            kc_r <= 2'd0;
            if (kr_r == 2'd2) begin
              kr_r   <= 2'd0;
              k_r    <= 4'd0;
              slot_r <= eslot_r;
              ch_r   <= ch_r + 6'd1;
            end else begin
              kr_r   <= kr_r + 2'd1;
              slot_r <= (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
            end
          end else begin
            kc_r <= kc_r + 2'd1;
          end
          if (last_tap) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1_r && !v2_r) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_row_r   <= er_r;
            out_col_r   <= ec_r;
            out_ch_r2   <= f_r;
            out_val_r   <= relu;
            out_last_r  <= (7'(f_r) + 7'd1 == out_ch_r);
            f_r         <= f_r + 6'd1;
            state_r     <= (7'(f_r) + 7'd1 == out_ch_r) ? S_IDLE : S_BIAS;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_val_r, out_ch_r2, out_col_r, out_row_r};

endmodule

// ===== hdl/c3br_ram.sv =====
module c3br_ram #(
  parameter int Width = 16,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== verif/tb_conv3x3_bias_relu.sv =====
module tb_conv3x3_bias_relu;
  import c3br_pkg::*;

  // one expected output transfer
  typedef struct {
    logic [4:0]  row;
    logic [4:0]  col;
    logic [5:0]  chan;
    logic [14:0] value;
    logic        last;
  } pixel_result_t;

  // Shadow model of the convolution plus the queue of results it still owes.
  class conv_scoreboard;
    shortint     weights[WeightDepth];
    shortint     biases[MaxOutCh];
    shortint     lines[3][LineCols][MaxInCh];  // 2-state, so all zero at start
    int unsigned pos_row, pos_col, pos_chan;
    int unsigned height, width, in_ch, out_ch;
    pixel_result_t pending[$];
    int          errors;

    function new();
      height  = 24;
      width   = 24;
      in_ch   = 3;
      out_ch  = 64;
      pos_row = 1;
      pos_col = 1;
      pos_chan = 0;
      errors  = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] data);
      case (idx)
        REG_HEIGHT: height = clamp(data, MaxHeight);
        REG_WIDTH:  width  = clamp(data, MaxWidth);
        REG_IN_CH:  in_ch  = clamp(data, MaxInCh);
        REG_OUT_CH: out_ch = clamp(data, MaxOutCh);
        default: ;
      endcase
      pos_row  = 1;
      pos_col  = 1;
      pos_chan = 0;
    endfunction

    // padded frame read: border and outside read as zero
    function longint tap(int unsigned r, int unsigned c, int unsigned ch);
      if (r < 1 || r > height || c < 1 || c > width) return 0;
      return longint'(lines[r % 3][c][ch]);
    endfunction

    function void emit_pixel();
      int unsigned   r0, c0;
      longint        acc;
      longint        rounded;
      pixel_result_t res;
      r0 = pos_row - 2;
      c0 = pos_col - 2;
      for (int f = 0; f < out_ch; f++) begin
        acc = longint'(biases[f]) * 256;
        for (int ch = 0; ch < in_ch; ch++)
          for (int kr = 0; kr < 3; kr++)
            for (int kc = 0; kc < 3; kc++)
              acc += tap(r0 + kr, c0 + kc, ch) *
                     longint'(weights[((kr * 3 + kc) * MaxInCh + ch) * MaxOutCh + f]);
        // ReLU, round to nearest (ties up), saturate
        if (acc <= 0) rounded = 0;
        else begin
          rounded = (acc + 128) >>> 8;
          if (rounded > 32767) rounded = 32767;
        end
        res.row   = r0[4:0];
        res.col   = c0[4:0];
        res.chan  = f[5:0];
        res.value = rounded[14:0];
        res.last  = (f + 1 == out_ch);
        pending.push_back(res);
      end
    endfunction

    function void advance();
      if (pos_row >= 2 && pos_col >= 2) emit_pixel();
      pos_col++;
      if (pos_col > width + 1) begin
        pos_col = 1;
        pos_row++;
        if (pos_row > height + 1) pos_row = 1;
      end
    endfunction

    function void note_input(op_t op, logic [15:0] idx, logic [15:0] val);
      bit interior;
      interior = pos_row <= height && pos_col <= width;
      case (op)
        OP_WEIGHT: if (idx < WeightDepth) weights[idx] = val;
        OP_BIAS:   if (idx < MaxOutCh) biases[idx] = val;
        OP_PIXEL: begin
          // pixels at border positions are dropped
          if (interior) begin
            lines[pos_row % 3][pos_col][pos_chan] = val;
            pos_chan++;
            if (pos_chan >= in_ch) begin
              pos_chan = 0;
              advance();
            end
          end
        end
        default: if (!interior) advance();  // flush inside the frame is dropped
      endcase
    endfunction

    function void check_result(logic [31:0] data, logic last);
      pixel_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result tdata=%h tlast=%b", $time, data, last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (data[4:0] !== want.row) begin
        $display("%0t: out_row expected %0d actual %0d", $time, want.row, data[4:0]);
        errors++;
      end
      if (data[9:5] !== want.col) begin
        $display("%0t: out_col expected %0d actual %0d", $time, want.col, data[9:5]);
        errors++;
      end
      if (data[15:10] !== want.chan) begin
        $display("%0t: out_channel expected %0d actual %0d", $time, want.chan,
                 data[15:10]);
        errors++;
      end
      if (data[30:16] !== want.value) begin
        $display("%0t: out_value expected %0d actual %0d", $time, want.value,
                 data[30:16]);
        errors++;
      end
      if (last !== want.last) begin
        $display("%0t: last expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] index, [31:16] value
  logic [1:0]  in_tuser;   // [1:0] op
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [4:0] row, [9:5] col, [15:10] channel, [30:16] value
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  conv_scoreboard sb;
  bit  calm;          // no idling on either side while set
  int  stall_left;
  int  traffic_items; // input transfers so far

  conv3x3_bias_relu uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Consumer: random backpressure, mostly short stalls, a few long ones.
  always @(posedge clk) begin
    int pick;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      pick = $urandom_range(99);
      if (!calm && pick < 20)
        stall_left = (pick < 2) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
  end

  // Output monitor: every result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
  end

  function automatic logic [15:0] rand_q88();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Producer gap before a transfer: mostly none, some short, a few long.
  task automatic source_gap();
    int pick;
    int n;
    pick = $urandom_range(99);
    n = 0;
    if (!calm) begin
      if (pick < 4) n = $urandom_range(30, 8);
      else if (pick < 30) n = $urandom_range(3, 1);
    end
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_item(op_t op, logic [15:0] idx, logic [15:0] val);
    source_gap();
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, idx};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, idx, val);
    traffic_items++;
  endtask

  // Let every owed result arrive, then wait for a trailing no-result item.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_frame(logic [15:0] h, logic [15:0] w, logic [15:0] ic,
                           logic [15:0] oc);
    drain();
    write_reg(REG_HEIGHT, h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_IN_CH, ic);
    write_reg(REG_OUT_CH, oc);
    cfg_valid <= 1'b0;
  endtask

  // Every weight and bias the current setting reads gets a fresh value.
  task automatic load_coeffs();
    for (int k = 0; k < 9; k++)
      for (int ch = 0; ch < sb.in_ch; ch++)
        for (int f = 0; f < sb.out_ch; f++)
          send_item(OP_WEIGHT, 16'((k * MaxInCh + ch) * MaxOutCh + f), rand_q88());
    for (int f = 0; f < sb.out_ch; f++)
      send_item(OP_BIAS, 16'(f), rand_q88());
  endtask

  // Junk: wrong item kind for the position or a load out of range (dropped), or a stray in-range weight.
  task automatic send_noise(bit interior);
    case ($urandom_range(3))
      0: send_item(interior ? OP_FLUSH : OP_PIXEL, 16'($urandom()), rand_q88());
      1: send_item(OP_WEIGHT, 16'($urandom_range(65535, WeightDepth)), rand_q88());
      2: send_item(OP_BIAS, 16'($urandom_range(65535, MaxOutCh)), rand_q88());
      default: send_item(OP_WEIGHT, 16'($urandom_range(WeightDepth - 1)), rand_q88());
    endcase
  endtask

  // One whole padded frame in raster order; noise_pct of positions get junk first.
  task automatic run_frame(int noise_pct);
    bit interior;
    for (int r = 1; r <= sb.height + 1; r++)
      for (int c = 1; c <= sb.width + 1; c++) begin
        interior = r <= sb.height && c <= sb.width;
        if ($urandom_range(99) < noise_pct) send_noise(interior);
        if (interior) begin
          for (int ch = 0; ch < sb.in_ch; ch++) begin
            send_item(OP_PIXEL, 16'($urandom()), rand_q88());
          end
        end else begin
          send_item(OP_FLUSH, 16'($urandom()), 16'($urandom()));
        end
      end
  endtask

  initial begin
    sb = new();
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_WEIGHT;
    cfg_valid = 1'b0;
    cfg_index = REG_HEIGHT;
    cfg_data  = '0;
    calm = 1'b0;
    traffic_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 1x1 frame from clamped zero writes, full-scale weights, out-of-range loads.
    set_frame(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int k = 0; k < 9; k++) send_item(OP_WEIGHT, 16'(k * MaxInCh * MaxOutCh), 16'h7FFF);
    send_item(OP_BIAS, 16'h0000, 16'h7FFF);
    send_item(OP_WEIGHT, 16'hFFFF, 16'h8000);  // out of range, dropped
    send_item(OP_BIAS, 16'hFFFF, 16'h8000);    // out of range, dropped
    send_item(OP_FLUSH, 16'h0000, 16'h0000);   // flush inside the frame, dropped
    send_item(OP_PIXEL, 16'hFFFF, 16'h7FFF);   // saturates
    send_item(OP_PIXEL, 16'h0000, 16'h1234);   // pixel on border, dropped
    send_item(OP_FLUSH, 16'h0000, 16'h0000);
    send_item(OP_FLUSH, 16'h0000, 16'h0000);
    send_item(OP_FLUSH, 16'h0000, 16'h0000);
    // negative sum: ReLU clamps at zero
    send_item(OP_PIXEL, 16'h0000, 16'h8000);
    repeat (3) send_item(OP_FLUSH, 16'h0000, 16'h0000);

    // Extreme settings, clamped writes among them.
    set_frame(16'hFFFF, 16'd1, 16'd1, 16'd1);
    load_coeffs();
    run_frame(5);
    set_frame(16'd1, 16'd40, 16'd1, 16'd2);
    load_coeffs();
    run_frame(5);

    // Random small frames; the sender pauses for the results at every reconfiguration.
    while (traffic_items < 220) begin
      set_frame(16'($urandom_range(4, 1)), 16'($urandom_range(4, 1)),
                16'($urandom_range(3, 1)), 16'($urandom_range(4, 1)));
      load_coeffs();
      repeat ($urandom_range(2, 1)) begin
        calm = ($urandom_range(3) == 0);
        run_frame(10);
      end
      calm = 1'b0;
    end

    drain();
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
